[design/first_fit_contiguous_allocator_defines.svh]
// Assertion macros used by the allocator control block.
// Define ASSERT_OFF to compile every assertion away.
`ifndef FIRST_FIT_CONTIGUOUS_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_CONTIGUOUS_ALLOCATOR_DEFINES_SVH

`ifndef ASSERT_OFF

// prop must hold at every rising edge outside reset
`define FFCA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// expr must never be true at a rising edge outside reset
`define FFCA_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`else

`define FFCA_ASSERT(lbl, clk, rstn, prop, msg)
`define FFCA_NEVER(lbl, clk, rstn, expr, msg)

`endif

`endif

[design/ffca_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ffca_pkg;

    // slot map geometry
    localparam int SLOTS      = 1024;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int CNT_W      = SLOT_W + 1;
    localparam int RUN_W      = CNT_W + 1;
    localparam int CELL_SLOTS = 32;
    localparam int CELL_W     = $clog2(CELL_SLOTS);
    localparam int NCELLS     = SLOTS / CELL_SLOTS;
    localparam int REF_W      = 16;
    localparam int APB_W      = 32;
    localparam int ADDR_W     = 3;

    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [RUN_W-1:0]  run_t;
    typedef logic [CELL_W-1:0] cidx_t;
    typedef logic [REF_W-1:0]  ref_t;

    // opcodes
    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // register index (taken from paddr[2])
    localparam logic REG_ACTIVE = 1'b0;

    localparam cnt_t ACTIVE_RESET = cnt_t'(SLOTS);

    // search token handed from cell to cell
    typedef struct packed {
        logic  valid;
        logic  found;
        cnt_t  run;
        slot_t start;
    } tok_t;

    // range command broadcast to all cells
    typedef struct packed {
        logic  valid;
        logic  set_free;
        slot_t lo;
        slot_t hi;
    } cmd_t;

endpackage

`default_nettype wire

[design/first_fit_contiguous_allocator.sv]
`timescale 1ns / 1ps
`default_nettype none

// First-fit contiguous run allocator over a 1024-slot map held in a row of
// 32 cells of 32 slots each. An allocate word is refused at once (done in
// the next cycle) when its run length is zero or exceeds the active slots;
// otherwise a search token walks the cell row, one cell per cycle, and done
// follows once the token leaves the last cell, after the apply step for a
// grant. A release word gives done after its apply step. The result word is
// on granted/grant_start/refusals for the single cycle that done is high and
// cannot be stalled: capture it then. refusals is also valid at any time as
// the running count. A new word may be started in the cycle done is high.
// Writing active_slots frees every slot in the same cycle; write it only
// while busy is low.

module first_fit_contiguous_allocator (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // command
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic                        opcode,
    input  wire logic [ffca_pkg::CNT_W-1:0]  run_length,
    input  wire logic [ffca_pkg::SLOT_W-1:0] range_first,
    input  wire logic [ffca_pkg::SLOT_W-1:0] range_last,
    // result
    output logic                             done,
    output logic                             granted,
    output logic [ffca_pkg::SLOT_W-1:0]      grant_start,
    output logic [ffca_pkg::REF_W-1:0]       refusals,
    // configuration
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [ffca_pkg::ADDR_W-1:0] paddr,
    input  wire logic [ffca_pkg::APB_W-1:0]  pwdata,
    output logic [ffca_pkg::APB_W-1:0]       prdata,
    output logic                             pready
);
    import ffca_pkg::*;

    cnt_t active_reg;
    cnt_t act;
    logic cfg_wr;
    tok_t tok_link [NCELLS+1];
    cmd_t ctrl_cmd;
    cmd_t cell_cmd;
    cnt_t len;

    // configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == REG_ACTIVE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            active_reg <= ACTIVE_RESET;
        else if (cfg_wr)
            active_reg <= pwdata[CNT_W-1:0];
    end

    assign prdata = (paddr[2] == REG_ACTIVE) ? APB_W'(active_reg) : '0;
    assign act    = (active_reg > cnt_t'(SLOTS)) ? cnt_t'(SLOTS) : active_reg;

    // a register write frees the whole map
    always_comb
    begin
        cell_cmd = ctrl_cmd;
        if (cfg_wr)
        begin
            cell_cmd.valid    = 1'b1;
            cell_cmd.set_free = 1'b1;
            cell_cmd.lo       = '0;
            cell_cmd.hi       = '1;
        end
    end

    ffca_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .opcode      (opcode),
        .run_length  (run_length),
        .range_first (range_first),
        .range_last  (range_last),
        .act         (act),
        .last_tok    (tok_link[NCELLS]),
        .busy        (busy),
        .tok_launch  (tok_link[0]),
        .cmd         (ctrl_cmd),
        .len         (len),
        .done        (done),
        .granted     (granted),
        .grant_start (grant_start),
        .refusals    (refusals)
    );

    // row of slot cells
    for (genvar c = 0; c < NCELLS; c++)
    begin : g_cell
        ffca_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .base    (slot_t'(c * CELL_SLOTS)),
            .act     (act),
            .len     (len),
            .cmd     (cell_cmd),
            .tok_in  (tok_link[c]),
            .tok_out (tok_link[c+1])
        );
    end

endmodule

`default_nettype wire

[design/ffca_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module ffca_cell (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire ffca_pkg::slot_t base,
    input  wire ffca_pkg::cnt_t  act,
    input  wire ffca_pkg::cnt_t  len,
    input  wire ffca_pkg::cmd_t  cmd,
    input  wire ffca_pkg::tok_t  tok_in,
    output ffca_pkg::tok_t       tok_out
);
    import ffca_pkg::*;

    logic [CELL_SLOTS-1:0] free_reg;
    logic [CELL_SLOTS-1:0] free_next;
    tok_t                  tok_reg;
    tok_t                  tok_next;

    logic [CELL_SLOTS-1:0] avail;
    logic [CELL_SLOTS-1:0] hit;
    run_t                  run_arr [CELL_SLOTS];
    cidx_t                 hit_idx;
    logic                  any_hit;

    // free and inside the active range
    always_comb
    begin
        for (int j = 0; j < CELL_SLOTS; j++)
        begin
            avail[j] = free_reg[j] & ((cnt_t'(base) + cnt_t'(j)) < act);
        end
    end

    // length of the free run ending at each slot, counting the run carried in
    always_comb
    begin
        logic  allf;
        cidx_t z;
        allf = 1'b1;
        z    = '0;
        for (int j = 0; j < CELL_SLOTS; j++)
        begin
            allf = 1'b1;
            z    = '0;
            for (int k = 0; k <= j; k++)
            begin
                if (!avail[k])
                begin
                    allf = 1'b0;
                    z    = cidx_t'(k);
                end
            end
            if (allf)
                run_arr[j] = run_t'(tok_in.run) + run_t'(j + 1);
            else
                run_arr[j] = run_t'(j) - run_t'(z);
            hit[j] = (run_arr[j] >= run_t'(len));
        end
    end

    // lowest slot where a long enough run ends
    always_comb
    begin
        hit_idx = '0;
        for (int j = CELL_SLOTS - 1; j >= 0; j--)
        begin
            if (hit[j])
                hit_idx = cidx_t'(j);
        end
        any_hit = |hit;
    end

    // token update
    always_comb
    begin
        tok_next       = tok_in;
        tok_next.valid = tok_in.valid;
        if (tok_in.valid && !tok_in.found)
        begin
            if (any_hit)
            begin
                tok_next.found = 1'b1;
                tok_next.start = slot_t'(run_t'(base) + run_t'(hit_idx) + run_t'(1)
                                         - run_t'(len));
            end
            else
            begin
                tok_next.run = cnt_t'(run_arr[CELL_SLOTS-1]);
            end
        end
    end

    // range set or clear of this cell's slots
    always_comb
    begin
        slot_t idx;
        idx       = '0;
        free_next = free_reg;
        if (cmd.valid)
        begin
            for (int j = 0; j < CELL_SLOTS; j++)
            begin
                idx = base + slot_t'(j);
                if (idx >= cmd.lo && idx <= cmd.hi)
                    free_next[j] = cmd.set_free;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg <= '1;
            tok_reg  <= '0;
        end
        else
        begin
            free_reg <= free_next;
            tok_reg  <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

[design/ffca_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "first_fit_contiguous_allocator_defines.svh"

module ffca_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic            opcode,
    input  wire ffca_pkg::cnt_t  run_length,
    input  wire ffca_pkg::slot_t range_first,
    input  wire ffca_pkg::slot_t range_last,
    input  wire ffca_pkg::cnt_t  act,
    input  wire ffca_pkg::tok_t  last_tok,
    output logic                 busy,
    output ffca_pkg::tok_t       tok_launch,
    output ffca_pkg::cmd_t       cmd,
    output ffca_pkg::cnt_t       len,
    output logic                 done,
    output logic                 granted,
    output ffca_pkg::slot_t      grant_start,
    output ffca_pkg::ref_t       refusals
);
    import ffca_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_APPLY
    } state_t;

    state_t state_reg, state_next;
    cnt_t   len_reg, len_next;
    tok_t   tok_reg, tok_next;
    cmd_t   cmd_reg, cmd_next;
    logic   done_reg, done_next;
    logic   granted_reg, granted_next;
    slot_t  start_reg, start_next;
    ref_t   refusal_reg, refusal_next;

    slot_t  rel_last;
    logic   rel_ok;
    logic   alloc_ok;
    ref_t   refusal_inc;

    // release range clipped to the active slots
    always_comb
    begin
        cnt_t act_m1;
        act_m1   = act - cnt_t'(1);
        rel_last = (cnt_t'(range_last) >= act) ? act_m1[SLOT_W-1:0] : range_last;
        rel_ok   = (act != '0) && (range_first <= rel_last);
        alloc_ok = (run_length != '0) && (run_length <= act);
    end

    assign refusal_inc = (refusal_reg == '1) ? refusal_reg : refusal_reg + ref_t'(1);

    // next state
    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        tok_next       = tok_reg;
        tok_next.valid = 1'b0;
        cmd_next       = cmd_reg;
        cmd_next.valid = 1'b0;
        done_next      = 1'b0;
        granted_next   = granted_reg;
        start_next     = start_reg;
        refusal_next   = refusal_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (opcode == OP_RELEASE)
                    begin
                        cmd_next.valid    = rel_ok;
                        cmd_next.set_free = 1'b1;
                        cmd_next.lo       = range_first;
                        cmd_next.hi       = rel_last;
                        granted_next      = 1'b0;
                        start_next        = '0;
                        state_next        = ST_APPLY;
                    end
                    else if (alloc_ok)
                    begin
                        len_next       = run_length;
                        tok_next.valid = 1'b1;
                        tok_next.found = 1'b0;
                        tok_next.run   = '0;
                        tok_next.start = '0;
                        state_next     = ST_SEARCH;
                    end
                    else
                    begin
                        done_next    = 1'b1;
                        granted_next = 1'b0;
                        start_next   = '0;
                        refusal_next = refusal_inc;
                    end
                end
            end

            ST_SEARCH:
            begin
                if (last_tok.valid)
                begin
                    if (last_tok.found)
                    begin
                        cmd_next.valid    = 1'b1;
                        cmd_next.set_free = 1'b0;
                        cmd_next.lo       = last_tok.start;
                        cmd_next.hi       = last_tok.start + len_reg[SLOT_W-1:0]
                                            - slot_t'(1);
                        granted_next      = 1'b1;
                        start_next        = last_tok.start;
                        state_next        = ST_APPLY;
                    end
                    else
                    begin
                        done_next    = 1'b1;
                        granted_next = 1'b0;
                        start_next   = '0;
                        refusal_next = refusal_inc;
                        state_next   = ST_IDLE;
                    end
                end
            end

            ST_APPLY:
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            len_reg     <= '0;
            tok_reg     <= '0;
            cmd_reg     <= '0;
            done_reg    <= 1'b0;
            granted_reg <= 1'b0;
            start_reg   <= '0;
            refusal_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            tok_reg     <= tok_next;
            cmd_reg     <= cmd_next;
            done_reg    <= done_next;
            granted_reg <= granted_next;
            start_reg   <= start_next;
            refusal_reg <= refusal_next;
        end
    end

    assign busy        = (state_reg != ST_IDLE);
    assign tok_launch  = tok_reg;
    assign cmd         = cmd_reg;
    assign len         = len_reg;
    assign done        = done_reg;
    assign granted     = granted_reg;
    assign grant_start = start_reg;
    assign refusals    = refusal_reg;

    // a launched token comes out of the last cell after passing every cell register
    `FFCA_ASSERT(a_tok_return, clk, rst_n, tok_reg.valid |-> ##NCELLS last_tok.valid, "token lost in chain")
    // map commands only issue from the apply step
    `FFCA_NEVER(a_cmd_state, clk, rst_n, cmd_reg.valid && (state_reg != ST_APPLY), "stray map command")
    // a word without a grant carries start zero
    `FFCA_ASSERT(a_nogrant_start, clk, rst_n, (done_reg && !granted_reg) |-> (start_reg == '0), "start without grant")
    // refusal count only steps up by one
    `FFCA_ASSERT(a_ref_step, clk, rst_n, (refusal_reg != $past(refusal_reg)) |-> (refusal_reg == $past(refusal_reg) + ref_t'(1)), "refusal count jump")

endmodule

`default_nettype wire

[test/first_fit_contiguous_allocator_test.sv]
`timescale 1ns / 1ps

module first_fit_contiguous_allocator_test;
    import ffca_pkg::*;

    // register map: index sits on paddr[2]
    localparam int                REG_SEL_BIT  = 2;
    localparam logic [ADDR_W-1:0] ADDR_ACTIVE  = {REG_ACTIVE, 2'b00};
    localparam logic [ADDR_W-1:0] ADDR_SPARE   = {~REG_ACTIVE, 2'b00};

    // quiet time after each test, longer than a search through all 32 cells
    localparam int DRAIN_CYCLES = 40;
    localparam int IDLE_LIMIT   = 4000;
    localparam int PRINT_CAP    = 200;
    localparam int FAST_REFUSALS = 100;

    // expected result word and a granted run kept for later release
    typedef struct {
        logic  granted;
        slot_t grant_start;
        ref_t  refusals;
    } grant_word_t;

    typedef struct {
        slot_t first;
        cnt_t  len;
    } run_rec_t;

    logic              clk;
    logic              rst_n       = 1'b0;
    logic              start       = 1'b0;
    logic              busy;
    logic              opcode      = OP_ALLOC;
    logic [CNT_W-1:0]  run_length  = '0;
    logic [SLOT_W-1:0] range_first = '0;
    logic [SLOT_W-1:0] range_last  = '0;
    logic              done;
    logic              granted;
    logic [SLOT_W-1:0] grant_start;
    logic [REF_W-1:0]  refusals;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [ADDR_W-1:0] paddr       = '0;
    logic [APB_W-1:0]  pwdata      = '0;
    logic [APB_W-1:0]  prdata;
    logic              pready;

    // allocator shadow state
    bit [SLOTS-1:0] slot_free_shadow = '1;
    cnt_t           active_shadow    = ACTIVE_RESET;
    ref_t           refusal_shadow   = '0;

    grant_word_t expected_words[$];
    run_rec_t    live_runs[$];
    int          mismatches  = 0;
    int          idle_cycles = 0;

    first_fit_contiguous_allocator DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .opcode      (opcode),
        .run_length  (run_length),
        .range_first (range_first),
        .range_last  (range_last),
        .done        (done),
        .granted     (granted),
        .grant_start (grant_start),
        .refusals    (refusals),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // managed slot count, saturated to the map size
    function automatic int managed_slots();
        return (active_shadow > SLOTS) ? SLOTS : int'(active_shadow);
    endfunction

    // first-fit allocate or clipped release; updates the shadow map
    function automatic grant_word_t predict_grant(input logic op, input cnt_t len,
                                                  input slot_t first, input slot_t last);
        grant_word_t w;
        int          span;
        int          hi;
        int          run;
        int          pos;
        logic        hit;
        span          = managed_slots();
        w.granted     = 1'b0;
        w.grant_start = '0;
        hit           = 1'b0;
        pos           = 0;
        if (op == OP_RELEASE)
        begin
            hi = last;
            if (span > 0 && hi >= span)
                hi = span - 1;
            if (span > 0)
                for (int i = first; i <= hi; i++)
                    slot_free_shadow[i] = 1'b1;
        end
        else
        begin
            if (len != 0 && len <= span)
            begin
                run = 0;
                for (int i = 0; i < span && !hit; i++)
                begin
                    if (slot_free_shadow[i])
                    begin
                        run++;
                        if (run == len)
                        begin
                            hit = 1'b1;
                            pos = i + 1 - len;
                        end
                    end
                    else
                        run = 0;
                end
            end
            if (hit)
            begin
                for (int i = pos; i < pos + len; i++)
                    slot_free_shadow[i] = 1'b0;
                w.granted     = 1'b1;
                w.grant_start = slot_t'(pos);
                live_runs.push_back('{slot_t'(pos), len});
            end
            else if (refusal_shadow != '1)
                refusal_shadow++;
        end
        w.refusals = refusal_shadow;
        return w;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
    endtask

    // drive one command word and hold it until accepted
    task automatic send_word(input logic op, input cnt_t len,
                             input slot_t first, input slot_t last);
        start       <= 1'b1;
        opcode      <= op;
        run_length  <= len;
        range_first <= first;
        range_last  <= last;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_words.push_back(predict_grant(op, len, first, last));
    endtask

    task automatic pause(input int cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // wait for every outstanding result, then let the block go quiet
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (expected_words.size() != 0 || busy)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [APB_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        // a write to the slot count clears the whole map
        if (addr[REG_SEL_BIT] == REG_ACTIVE)
        begin
            active_shadow    = data[CNT_W-1:0];
            slot_free_shadow = '1;
            live_runs.delete();
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read_check(input logic [ADDR_W-1:0] addr);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== APB_W'(active_shadow))
            report_mismatch("prdata", prdata, active_shadow);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // full map, empty-length and oversize requests, reversed release
    task automatic test_reset_limits();
        apb_read_check(ADDR_ACTIVE);
        send_word(OP_ALLOC, cnt_t'(SLOTS), '0, '0);
        send_word(OP_ALLOC, cnt_t'(1), '0, '0);
        send_word(OP_ALLOC, cnt_t'(0), '0, '0);
        send_word(OP_ALLOC, cnt_t'(SLOTS + 1), '0, '0);
        send_word(OP_ALLOC, '1, '1, '1);
        send_word(OP_RELEASE, '0, '1, '0);
        send_word(OP_ALLOC, cnt_t'(1), '0, '0);
        send_word(OP_RELEASE, '0, '0, '1);
        settle();
    endtask

    // lowest start wins, including runs across the middle of the map
    task automatic test_first_fit();
        send_word(OP_ALLOC, cnt_t'(600), '0, '0);
        send_word(OP_ALLOC, cnt_t'(300), '0, '0);
        send_word(OP_ALLOC, cnt_t'(124), '0, '0);
        send_word(OP_RELEASE, '0, slot_t'(500), slot_t'(700));
        send_word(OP_RELEASE, '0, slot_t'(10), slot_t'(19));
        send_word(OP_ALLOC, cnt_t'(8), '0, '0);
        send_word(OP_ALLOC, cnt_t'(150), '0, '0);
        send_word(OP_ALLOC, cnt_t'(60), '0, '0);
        send_word(OP_RELEASE, '0, '0, '1);
        settle();
    endtask

    // clipping to the active range, ignored register, zero and oversized counts
    task automatic test_active_range();
        apb_write(ADDR_ACTIVE, APB_W'(64));
        apb_read_check(ADDR_ACTIVE);
        send_word(OP_ALLOC, cnt_t'(64), '0, '0);
        send_word(OP_RELEASE, '0, slot_t'(60), '1);
        send_word(OP_ALLOC, cnt_t'(4), '0, '0);
        send_word(OP_RELEASE, '0, slot_t'(100), slot_t'(200));
        send_word(OP_ALLOC, cnt_t'(65), '0, '0);
        settle();
        apb_write(ADDR_SPARE, APB_W'(5));
        send_word(OP_ALLOC, cnt_t'(1), '0, '0);
        settle();
        apb_write(ADDR_ACTIVE, APB_W'(1));
        send_word(OP_ALLOC, cnt_t'(1), '0, '0);
        send_word(OP_ALLOC, cnt_t'(2), '0, '0);
        settle();
        apb_write(ADDR_ACTIVE, APB_W'(0));
        send_word(OP_ALLOC, cnt_t'(1), '0, '0);
        send_word(OP_RELEASE, '0, '0, '1);
        settle();
        apb_write(ADDR_ACTIVE, APB_W'(2047));
        apb_read_check(ADDR_ACTIVE);
        send_word(OP_ALLOC, cnt_t'(SLOTS), '0, '0);
        send_word(OP_ALLOC, cnt_t'(1), '0, '0);
        settle();
    endtask

    // one slot-count setting, then mixed traffic in bursts with random gaps
    task automatic run_random_phase(input cnt_t setting, input int count);
        int       burst_left;
        int       gap;
        int       pick;
        int       span;
        int       idx;
        logic     op;
        cnt_t     len;
        slot_t    first;
        slot_t    last;
        run_rec_t victim;
        apb_write(ADDR_ACTIVE, ($urandom() & ~APB_W'(32'h7FF)) | APB_W'(setting));
        apb_read_check(ADDR_ACTIVE);
        burst_left = 0;
        gap        = 0;
        for (int n = 0; n < count; n++)
        begin
            span  = (managed_slots() < 1) ? 1 : managed_slots();
            pick  = $urandom_range(0, 99);
            op    = OP_ALLOC;
            len   = cnt_t'($urandom());
            first = slot_t'($urandom());
            last  = slot_t'($urandom());
            if (pick < 45)
                len = cnt_t'($urandom_range(1, (span < 32) ? span : 32));
            else if (pick < 55)
                len = cnt_t'($urandom_range(1, span));
            else if (pick >= 60)
            begin
                op = OP_RELEASE;
                // free a run handed out earlier, else a short or wild range
                if (pick < 85 && live_runs.size() != 0)
                begin
                    idx    = $urandom_range(0, live_runs.size() - 1);
                    victim = live_runs[idx];
                    live_runs.delete(idx);
                    first  = victim.first;
                    last   = slot_t'(victim.first + victim.len - 1);
                end
                else if (pick < 95)
                begin
                    first = slot_t'($urandom_range(0, span - 1));
                    last  = slot_t'(first + $urandom_range(0, 40));
                end
            end
            send_word(op, len, first, last);
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 16);
                gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            end
            burst_left--;
            pause((burst_left == 0) ? gap : 0);
        end
        settle();
    endtask

    task automatic test_random_traffic();
        run_random_phase(ACTIVE_RESET, 300);
        run_random_phase(cnt_t'(1000), 250);
        run_random_phase(cnt_t'(64), 250);
        run_random_phase(cnt_t'(2), 100);
        run_random_phase(cnt_t'(1), 60);
        run_random_phase(cnt_t'(513), 250);
        run_random_phase(cnt_t'(0), 40);
        run_random_phase(cnt_t'(2047), 250);
        run_random_phase(cnt_t'($urandom_range(1, SLOTS)), 250);
        run_random_phase(cnt_t'($urandom()), 250);
    endtask

    // back-to-back fast refusals, then a full grab and a release
    task automatic test_fast_refusals();
        apb_write(ADDR_ACTIVE, APB_W'(64));
        repeat (FAST_REFUSALS)
            send_word(OP_ALLOC, $urandom_range(0, 1) ? cnt_t'(0) : cnt_t'($urandom_range(65, 2047)),
                      slot_t'($urandom()), slot_t'($urandom()));
        send_word(OP_ALLOC, cnt_t'(0), '0, '0);
        send_word(OP_ALLOC, '1, '0, '0);
        send_word(OP_ALLOC, cnt_t'(64), '0, '0);
        send_word(OP_ALLOC, cnt_t'(1), '0, '0);
        send_word(OP_RELEASE, '0, '0, '1);
        settle();
    endtask

    // compare each result word with the oldest expectation
    always @(posedge clk)
    begin : result_check
        grant_word_t want;
        if (rst_n && done)
        begin
            if (expected_words.size() == 0)
                report_mismatch("unexpected done, grant_start", grant_start, 0);
            else
            begin
                want = expected_words.pop_front();
                if (granted !== want.granted)
                    report_mismatch("granted", granted, want.granted);
                if (grant_start !== want.grant_start)
                    report_mismatch("grant_start", grant_start, want.grant_start);
                if (refusals !== want.refusals)
                    report_mismatch("refusals", refusals, want.refusals);
            end
        end
    end

    // watchdog on cycles without any word moving
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("first_fit_contiguous_allocator test failed");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_limits();
        test_first_fit();
        test_active_range();
        test_random_traffic();
        test_fast_refusals();
        if (mismatches == 0)
            $display("first_fit_contiguous_allocator test passed");
        else
            $display("first_fit_contiguous_allocator test failed");
        $finish;
    end

endmodule
